// ===== hw/rtl/srfc_pkg.sv =====
// ---------------------------------------------------------------------------
// srfc_pkg
// Shared types and constants of the sensor reply frame checker.
// ---------------------------------------------------------------------------
`default_nettype none

package srfc_pkg;

   // Highest sensor count accepted in a sensor frame
   localparam int MAX_SENSORS = 4;
   // Bits for the data byte counters (up to 3 bytes per sensor)
   localparam int CONTENT_W   = $clog2(3 * MAX_SENSORS + 1);
   // Depth of the queue between front and back
   localparam int Q_DEPTH     = 4;
   localparam int Q_PTR_W     = $clog2(Q_DEPTH);
   localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

   localparam logic [7:0] HDR_BYTE    = 8'hfe;
   localparam logic [7:0] TAIL_BYTE   = 8'hfd;
   localparam logic [7:0] TYPE_SENSOR = 8'h03;
   localparam logic [7:0] TYPE_POWER  = 8'h02;
   localparam logic [7:0] RECV_ADDR   = 8'h00;

   localparam logic [CONTENT_W-1:0] POWER_LEN = CONTENT_W'(3);

   // Register map, word index
   localparam logic REG_NODE_ID = 1'b0;
   localparam logic [7:0] NODE_ID_RESET = 8'h01;

   typedef enum logic [3:0] {
      PH_HUNT1,
      PH_HUNT2,
      PH_SENDER,
      PH_RECEIVER,
      PH_TYPE,
      PH_COUNT,
      PH_CONTENT,
      PH_CHECK,
      PH_TAIL1,
      PH_TAIL2
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_CSUM  = 3'd1,
      ST_TAIL  = 3'd2,
      ST_ADDR  = 3'd3,
      ST_TYPE  = 3'd4,
      ST_COUNT = 3'd5
   } status_type;

   // One request byte with its classification
   typedef struct packed {
      logic [7:0]           rx_byte;
      logic                 is_hdr;
      logic                 is_tail;
      logic                 is_sensor;
      logic                 is_power;
      logic                 is_recv;
      logic                 node_ok;
      logic                 count_big;
      logic [CONTENT_W-1:0] content_len;
   } class_type;

   // Queue status toward the front and back
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

`default_nettype wire

// ===== hw/rtl/srfc_if.sv =====
// ---------------------------------------------------------------------------
// srfc channel interfaces
// Request channel (received bytes) and response channel (per-byte results).
// ---------------------------------------------------------------------------
`default_nettype none

interface srfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface srfc_rsp_if;
   logic       valid;
   logic       ready;
   logic       payload_valid;
   logic [7:0] payload_byte;
   logic [7:0] payload_index;
   logic       frame_done;
   logic [2:0] frame_status;
   logic       frame_kind;
   logic [6:0] sensor_total;

   modport source (output valid, output payload_valid, output payload_byte,
                   output payload_index, output frame_done, output frame_status,
                   output frame_kind, output sensor_total, input ready);
   modport sink (input valid, input payload_valid, input payload_byte,
                 input payload_index, input frame_done, input frame_status,
                 input frame_kind, input sensor_total, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/srfc_front.sv =====
// ---------------------------------------------------------------------------
// srfc_front
// Accepts request bytes, classifies them and pushes them into the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module srfc_front (
   srfc_req_if.sink             req,
   input  wire logic [7:0]      node_id,
   input  wire srfc_pkg::q_stat_type q_stat,
   output logic                 push_valid,
   output srfc_pkg::class_type  push_item
);

   logic [9:0] triple;

   assign req.ready  = !q_stat.full;
   assign push_valid = req.valid && !q_stat.full;

   // 3 * byte; only meaningful when the count is in range
   assign triple = {2'b00, req.rx_byte} + {1'b0, req.rx_byte, 1'b0};

   always_comb begin
      push_item.rx_byte     = req.rx_byte;
      push_item.is_hdr      = (req.rx_byte == srfc_pkg::HDR_BYTE);
      push_item.is_tail     = (req.rx_byte == srfc_pkg::TAIL_BYTE);
      push_item.is_sensor   = (req.rx_byte == srfc_pkg::TYPE_SENSOR);
      push_item.is_power    = (req.rx_byte == srfc_pkg::TYPE_POWER);
      push_item.is_recv     = (req.rx_byte == srfc_pkg::RECV_ADDR);
      push_item.node_ok     = (req.rx_byte == node_id);
      push_item.count_big   = (req.rx_byte > 8'(srfc_pkg::MAX_SENSORS));
      push_item.content_len = triple[srfc_pkg::CONTENT_W-1:0];
   end

endmodule

`default_nettype wire

// ===== hw/rtl/srfc_queue.sv =====
// ---------------------------------------------------------------------------
// srfc_queue
// Short FIFO of classified bytes between the front and the back.
// ---------------------------------------------------------------------------
`default_nettype none

module srfc_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   input  wire srfc_pkg::class_type push_item,
   input  wire logic                pop,
   output srfc_pkg::q_stat_type     q_stat,
   output srfc_pkg::class_type      head_item
);

   srfc_pkg::class_type                entry_ff [srfc_pkg::Q_DEPTH];
   logic [srfc_pkg::Q_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [srfc_pkg::Q_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [srfc_pkg::Q_CNT_W-1:0]       count_ff, count_in;
   logic                               do_push, do_pop;

   assign q_stat.full  = (count_ff == srfc_pkg::Q_CNT_W'(srfc_pkg::Q_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign head_item    = entry_ff[rd_ptr_ff];

   assign do_push = push_valid && !q_stat.full;
   assign do_pop  = pop && !q_stat.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == srfc_pkg::Q_PTR_W'(srfc_pkg::Q_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == srfc_pkg::Q_PTR_W'(srfc_pkg::Q_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/srfc_back.sv =====
// ---------------------------------------------------------------------------
// srfc_back
// Frame parser: walks the frame layout one byte at a time and registers
// the per-byte result for the response channel.
// ---------------------------------------------------------------------------
`default_nettype none

module srfc_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire srfc_pkg::q_stat_type q_stat,
   input  wire srfc_pkg::class_type  head_item,
   output logic                      pop,
   srfc_rsp_if.source                rsp
);

   srfc_pkg::phase_type               phase_ff, phase_in;
   logic [7:0]                        xor_ff, xor_in;
   logic [srfc_pkg::CONTENT_W-1:0]    left_ff, left_in;
   logic [srfc_pkg::CONTENT_W-1:0]    pos_ff, pos_in;
   logic [6:0]                        count_ff, count_in;
   logic                              kind_ff, kind_in;
   srfc_pkg::status_type              pend_ff, pend_in;

   logic                              rsp_valid_ff;
   logic                              pv_ff, pv_in;
   logic [7:0]                        pb_ff, pb_in;
   logic [srfc_pkg::CONTENT_W-1:0]    pi_ff, pi_in;
   logic                              done_ff, done_in;
   srfc_pkg::status_type              status_ff, status_in;
   logic                              kind_out_ff;
   logic [6:0]                        total_ff;

   logic                              step;
   logic [7:0]                        b;

   assign b    = head_item.rx_byte;
   // Take the next byte whenever the output register is free or drains
   assign pop  = !q_stat.empty && (!rsp_valid_ff || rsp.ready);
   assign step = pop;

   always_comb begin
      phase_in  = phase_ff;
      xor_in    = xor_ff;
      left_in   = left_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      kind_in   = kind_ff;
      pend_in   = pend_ff;
      pv_in     = 1'b0;
      pb_in     = '0;
      pi_in     = '0;
      done_in   = 1'b0;
      status_in = srfc_pkg::ST_OK;

      unique case (phase_ff)
         srfc_pkg::PH_HUNT1: begin
            if (head_item.is_hdr) begin
               phase_in = srfc_pkg::PH_HUNT2;
            end
         end
         srfc_pkg::PH_HUNT2: begin
            phase_in = head_item.is_hdr ? srfc_pkg::PH_SENDER : srfc_pkg::PH_HUNT1;
         end
         srfc_pkg::PH_SENDER: begin
            // start of a new frame: drop everything from the last one
            xor_in   = b;
            left_in  = '0;
            pos_in   = '0;
            count_in = '0;
            kind_in  = 1'b0;
            pend_in  = head_item.node_ok ? srfc_pkg::ST_OK : srfc_pkg::ST_ADDR;
            phase_in = srfc_pkg::PH_RECEIVER;
         end
         srfc_pkg::PH_RECEIVER: begin
            xor_in = xor_ff ^ b;
            if (pend_ff != srfc_pkg::ST_OK || !head_item.is_recv) begin
               done_in   = 1'b1;
               status_in = srfc_pkg::ST_ADDR;
               phase_in  = srfc_pkg::PH_HUNT1;
            end else begin
               phase_in = srfc_pkg::PH_TYPE;
            end
         end
         srfc_pkg::PH_TYPE: begin
            xor_in = xor_ff ^ b;
            if (head_item.is_sensor) begin
               kind_in  = 1'b1;
               phase_in = srfc_pkg::PH_COUNT;
            end else if (head_item.is_power) begin
               kind_in  = 1'b0;
               left_in  = srfc_pkg::POWER_LEN;
               pos_in   = '0;
               phase_in = srfc_pkg::PH_CONTENT;
            end else begin
               done_in   = 1'b1;
               status_in = srfc_pkg::ST_TYPE;
               phase_in  = srfc_pkg::PH_HUNT1;
            end
         end
         srfc_pkg::PH_COUNT: begin
            xor_in = xor_ff ^ b;
            if (head_item.count_big) begin
               done_in   = 1'b1;
               status_in = srfc_pkg::ST_COUNT;
               phase_in  = srfc_pkg::PH_HUNT1;
            end else begin
               count_in = b[6:0];
               left_in  = head_item.content_len;
               pos_in   = '0;
               phase_in = (head_item.content_len == '0) ?
                          srfc_pkg::PH_CHECK : srfc_pkg::PH_CONTENT;
            end
         end
         srfc_pkg::PH_CONTENT: begin
            xor_in  = xor_ff ^ b;
            pv_in   = 1'b1;
            pb_in   = b;
            pi_in   = pos_ff;
            pos_in  = pos_ff + 1'b1;
            left_in = left_ff - 1'b1;
            if (left_ff == srfc_pkg::CONTENT_W'(1)) begin
               phase_in = srfc_pkg::PH_CHECK;
            end
         end
         srfc_pkg::PH_CHECK: begin
            pend_in  = (b == xor_ff) ? srfc_pkg::ST_OK : srfc_pkg::ST_CSUM;
            phase_in = srfc_pkg::PH_TAIL1;
         end
         srfc_pkg::PH_TAIL1: begin
            if (!head_item.is_tail) begin
               done_in   = 1'b1;
               status_in = (pend_ff != srfc_pkg::ST_OK) ? pend_ff : srfc_pkg::ST_TAIL;
               phase_in  = srfc_pkg::PH_HUNT1;
            end else begin
               phase_in = srfc_pkg::PH_TAIL2;
            end
         end
         srfc_pkg::PH_TAIL2: begin
            done_in = 1'b1;
            if (pend_ff != srfc_pkg::ST_OK) begin
               status_in = pend_ff;
            end else begin
               status_in = head_item.is_tail ? srfc_pkg::ST_OK : srfc_pkg::ST_TAIL;
            end
            phase_in = srfc_pkg::PH_HUNT1;
         end
         default: begin
            phase_in = srfc_pkg::PH_HUNT1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= srfc_pkg::PH_HUNT1;
         xor_ff       <= '0;
         left_ff      <= '0;
         pos_ff       <= '0;
         count_ff     <= '0;
         kind_ff      <= 1'b0;
         pend_ff      <= srfc_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            phase_ff <= phase_in;
            xor_ff   <= xor_in;
            left_ff  <= left_in;
            pos_ff   <= pos_in;
            count_ff <= count_in;
            kind_ff  <= kind_in;
            pend_ff  <= pend_in;
         end
         if (step) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         pv_ff       <= pv_in;
         pb_ff       <= pb_in;
         pi_ff       <= pi_in;
         done_ff     <= done_in;
         status_ff   <= status_in;
         kind_out_ff <= kind_in;
         total_ff    <= kind_in ? count_in : 7'd0;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.payload_valid = pv_ff;
   assign rsp.payload_byte  = pb_ff;
   assign rsp.payload_index = 8'(pi_ff);
   assign rsp.frame_done    = done_ff;
   assign rsp.frame_status  = status_ff;
   assign rsp.frame_kind    = kind_out_ff;
   assign rsp.sensor_total  = total_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/sensor_reply_frame_checker.sv =====
// ---------------------------------------------------------------------------
// sensor_reply_frame_checker
// Checks reply frames received byte by byte and reports one result per byte.
// ---------------------------------------------------------------------------
// Usage:
//   req carries one received byte per request (valid/ready). Every request
//   yields exactly one response on rsp: the data byte with its index when
//   the byte is frame content, and a done flag with status when a frame
//   ends (accepted or rejected), plus the frame kind and sensor count.
//   The csr_ port is APB-style; register 0 at byte address 0 holds the
//   expected sender node id (reset value 1).
//   A request accepted on req is written into the queue, then stepped by
//   the parser into the response register. Throughput is one byte per
//   cycle while rsp takes responses, set by the back end's parser step.
//   A four-entry queue sits between the classifying front end and the
//   parser, so while rsp stalls the queue fills with four requests before
//   req.ready drops; the response register holds until taken.
//   Reset (synchronous, active high) empties the queue, returns the parser
//   to hunting for the first header byte and restores the node id.
//   Change the node id only while no frame byte is in flight.
// ---------------------------------------------------------------------------
`default_nettype none

module sensor_reply_frame_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   srfc_req_if.sink         req,
   srfc_rsp_if.source       rsp,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [7:0]           node_id_q_ff;
   logic                 csr_write;
   logic                 push_valid;
   logic                 pop;
   srfc_pkg::class_type  push_item;
   srfc_pkg::class_type  head_item;
   srfc_pkg::q_stat_type q_stat;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == srfc_pkg::REG_NODE_ID);
   assign csr_prdata = (csr_paddr[2] == srfc_pkg::REG_NODE_ID) ?
                       {24'd0, node_id_q_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_q_ff <= srfc_pkg::NODE_ID_RESET;
      end else if (csr_write) begin
         node_id_q_ff <= csr_pwdata[7:0];
      end
   end

   srfc_front u_front (
      .req        (req),
      .node_id    (node_id_q_ff),
      .q_stat     (q_stat),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   srfc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .pop        (pop),
      .q_stat     (q_stat),
      .head_item  (head_item)
   );

   srfc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .head_item (head_item),
      .pop       (pop),
      .rsp       (rsp)
   );

endmodule

`default_nettype wire
